>>> rtl/ole_pkg.sv
package ole_pkg;

    localparam int DEPTH      = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MOVE   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd3;

    // Kind of rearrangement that the row of cells performs in an update.
    typedef enum logic [1:0] {
        SHIFT_NONE = 2'd0,
        SHIFT_INS  = 2'd1,
        SHIFT_DEL  = 2'd2,
        SHIFT_MOV  = 2'd3
    } shift_kind_t;

    typedef struct packed {
        logic              shift_en;
        shift_kind_t       kind;
        logic [IDX_W-1:0]  ins_pos;
        logic [IDX_W-1:0]  del_idx;
    } cell_ctrl_t;

endpackage

>>> rtl/ole_if.sv
interface ole_in_if
    import ole_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [31:0]         value;
    logic [4:0]          position;

    modport source (output valid, output mode, output value, output position, input ready);
    modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface ole_out_if
    import ole_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [4:0]          found_index;
    logic                found;
    logic [5:0]          entry_count;

    modport source (output valid, output status, output found_index, output found,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found_index, input found,
                    input entry_count, output ready);
endinterface

>>> rtl/ole_cell.sv
module ole_cell
    import ole_pkg::*;
(
    input  logic                  clk,
    input  logic [IDX_W-1:0]      cell_idx,
    input  cell_ctrl_t            ctrl,
    input  logic [VALUE_BITS-1:0] key,
    input  logic [VALUE_BITS-1:0] left_in,
    input  logic [VALUE_BITS-1:0] right_in,
    output logic [VALUE_BITS-1:0] entry,
    output logic                  hit
);

    logic [VALUE_BITS-1:0] entry_reg;
    logic [VALUE_BITS-1:0] entry_next;
    logic                  below_pos;
    logic                  at_pos;
    logic                  below_del;
    logic                  upto_del;

    assign below_pos = cell_idx < ctrl.ins_pos;
    assign at_pos    = cell_idx == ctrl.ins_pos;
    assign below_del = cell_idx < ctrl.del_idx;
    assign upto_del  = cell_idx <= ctrl.del_idx;

    // Each cell takes its own entry, a neighbor's entry or the key.
    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.kind)
            SHIFT_INS:
            begin
                if (at_pos)
                    entry_next = key;
                else if (!below_pos)
                    entry_next = left_in;
            end
            SHIFT_DEL:
            begin
                if (!below_del)
                    entry_next = right_in;
            end
            SHIFT_MOV:
            begin
                if (at_pos)
                    entry_next = key;
                else if (below_pos)
                    entry_next = below_del ? entry_reg : right_in;
                else
                    entry_next = upto_del ? left_in : entry_reg;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
            entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign hit   = entry_reg == key;

endmodule

>>> rtl/ordered_list_engine.sv
// Ordered list engine: keeps an ordered list of up to 32 identifiers, such as
// a window stacking order, in a row of cells that each hold one entry.
// The req channel carries one item per operation: push, insert at position,
// find, remove or move to position. The rsp channel returns exactly one item
// per request with the status, the index of the first match, a found flag
// and the entry count after the operation.
// An accepted item passes through the compare stage, where every cell
// compares its entry with the value and the first match is encoded, and
// then the update stage, where all cells shift toward or away from their
// neighbors at once. The response is registered when the update finishes.
// A new item is accepted in the same cycle that the previous one finishes,
// so the block works on one item at a time over the cell row.
// If the receiver stalls, the response waits in an output register and the
// item in the update stage holds until that register can take its result;
// req.ready then stays low. Reset clears the entry count and the handshake
// state; the stored entries need no reset since only held entries are read.
module ordered_list_engine
    import ole_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ole_in_if.sink    req,
    ole_out_if.source rsp
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [MODE_W-1:0]     mode_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  hit_reg;
    logic [IDX_W-1:0]      idx_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [IDX_W-1:0]      out_idx_reg;
    logic                  out_found_reg;
    logic [CNT_W-1:0]      out_count_reg;

    logic                  accept;
    logic                  can_finish;
    logic                  full;
    logic [CNT_W-1:0]      pos_ext;
    shift_kind_t           kind;
    logic [IDX_W-1:0]      ins_pos;
    cell_ctrl_t            ctrl;

    logic [VALUE_BITS-1:0] entries [DEPTH];
    logic [DEPTH-1:0]      cell_hit;
    logic                  first_hit;
    logic [IDX_W-1:0]      first_idx;

    // Handshake: a finishing item makes room for the next one at once.
    assign can_finish = (state_reg == ST_UPD) && (!out_valid_reg || rsp.ready);
    assign req.ready  = (state_reg == ST_IDLE) || can_finish;
    assign accept     = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: state_next = accept ? ST_CMP : ST_IDLE;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:
            begin
                if (can_finish)
                    state_next = accept ? ST_CMP : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Cell row: each cell sees both neighbors, the ends take a zero value; the left
    // one is never selected, the right one only fills the last cell on a removal.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [VALUE_BITS-1:0] left_w;
            logic [VALUE_BITS-1:0] right_w;
            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = entries[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = entries[g+1];
            end
            ole_cell u_cell (
                .clk      (clk),
                .cell_idx (IDX_W'(g)),
                .ctrl     (ctrl),
                .key      (value_reg),
                .left_in  (left_w),
                .right_in (right_w),
                .entry    (entries[g]),
                .hit      (cell_hit[g])
            );
        end
    endgenerate

    // First match among the held entries; index zero when there is none.
    always_comb
    begin
        first_hit = 1'b0;
        first_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (cell_hit[i] && (CNT_W'(i) < count_reg))
            begin
                first_hit = 1'b1;
                first_idx = IDX_W'(i);
            end
        end
    end

    // Operation decode in the update stage.
    assign full    = count_reg == CNT_W'(DEPTH);
    assign pos_ext = CNT_W'(pos_reg);

    always_comb
    begin
        status_next = STATUS_OK;
        kind        = SHIFT_NONE;
        ins_pos     = pos_reg;
        count_next  = count_reg;
        unique case (mode_reg)
            MODE_PUSH:
            begin
                if (full)
                    status_next = STATUS_FULL;
                else
                begin
                    kind       = SHIFT_INS;
                    ins_pos    = count_reg[IDX_W-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_INSERT:
            begin
                if (full)
                    status_next = STATUS_FULL;
                else if (pos_ext > count_reg)
                    status_next = STATUS_BEYOND;
                else
                begin
                    kind       = SHIFT_INS;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_FIND:
            begin
                if (!hit_reg)
                    status_next = STATUS_ABSENT;
            end
            MODE_REMOVE:
            begin
                if (!hit_reg)
                    status_next = STATUS_ABSENT;
                else
                begin
                    kind       = SHIFT_DEL;
                    count_next = count_reg - 1'b1;
                end
            end
            MODE_MOVE:
            begin
                if (hit_reg)
                begin
                    // A present value: the target is checked against the
                    // count that the removal would leave.
                    if (pos_ext > count_reg - 1'b1)
                        status_next = STATUS_BEYOND;
                    else
                        kind = SHIFT_MOV;
                end
                else if (full)
                    status_next = STATUS_FULL;
                else if (pos_ext > count_reg)
                    status_next = STATUS_BEYOND;
                else
                begin
                    kind       = SHIFT_INS;
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    assign ctrl.shift_en = can_finish && (kind != SHIFT_NONE);
    assign ctrl.kind     = kind;
    assign ctrl.ins_pos  = ins_pos;
    assign ctrl.del_idx  = idx_reg;

    assign out_valid_next = can_finish ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (can_finish)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= req.mode;
            value_reg <= req.value[VALUE_BITS-1:0];
            pos_reg   <= req.position[IDX_W-1:0];
        end
        if (state_reg == ST_CMP)
        begin
            hit_reg <= first_hit;
            idx_reg <= first_idx;
        end
        if (can_finish)
        begin
            status_reg    <= status_next;
            out_idx_reg   <= idx_reg;
            out_found_reg <= hit_reg;
            out_count_reg <= count_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_index = out_idx_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.entry_count = out_count_reg;

endmodule
